### rtl/multi_channel_led_pwm_assert.svh
// ----------------------------------------------------------------------------
// multi_channel_led_pwm assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_LED_PWM_ASSERT_SVH
`define MULTI_CHANNEL_LED_PWM_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MCLP_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("multi_channel_led_pwm assertion failed");
// Next-cycle implication.
`define MCLP_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("multi_channel_led_pwm assertion failed");
`else
`define MCLP_ASSERT_IMP(lbl, ant, con)
`define MCLP_ASSERT_NXT(lbl, ant, con)
`endif

`endif

### rtl/mclp_pkg.sv
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared constants, command codes and item types of the LED PWM block.
// ----------------------------------------------------------------------------
package mclp_pkg;

  localparam int unsigned LEVELS    = 10;
  localparam int unsigned RGB_COUNT = 3;
  localparam int unsigned COLOURS   = 3;
  localparam int unsigned CHANNELS  = 9;
  localparam int unsigned NUM_CH    = RGB_COUNT * COLOURS;
  localparam int unsigned CH_W      = $clog2(CHANNELS);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned RGB_W    = 2;
  localparam int unsigned COLOUR_W = 2;
  localparam int unsigned DUTY_W   = 4;
  localparam int unsigned PHASE_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SET    = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4
  } command_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [RGB_W-1:0]    rgb_index;
    logic [COLOUR_W-1:0] colour_index;
    logic [DUTY_W-1:0]   duty;
  } item_t;

  typedef struct packed {
    logic [CHANNELS-1:0] lit_mask;
    logic                rejected;
    logic                halted;
    logic [PHASE_W-1:0]  phase;
  } result_t;

endpackage

### rtl/mclp_state.sv
// ----------------------------------------------------------------------------
// mclp_state
// PWM state (duty table, phase, drive, pause) and its one-pass update.
// ----------------------------------------------------------------------------
module mclp_state (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  mclp_pkg::item_t item,
  output mclp_pkg::result_t res
);
  import mclp_pkg::*;

  logic [DUTY_W-1:0]   duty_r   [CHANNELS];
  logic [DUTY_W-1:0]   duty_nxt [CHANNELS];
  logic [PHASE_W-1:0]  phase_r, phase_nxt, phase_inc;
  logic [CHANNELS-1:0] drive_r, drive_nxt;
  logic                pause_r, pause_nxt;
  logic                frozen_r, frozen_nxt;
  logic                arg_ok;
  logic                rej;
  logic [CH_W-1:0]     ch_idx;

  assign arg_ok = (32'(item.rgb_index) < RGB_COUNT) && (32'(item.colour_index) < COLOURS)
                  && (32'(item.duty) <= LEVELS);
  assign ch_idx = CH_W'(32'(item.rgb_index) * COLOURS + 32'(item.colour_index));
  assign phase_inc = (32'(phase_r) + 1 == LEVELS) ? '0 : phase_r + 1'b1;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      duty_nxt[i] = duty_r[i];
    end
    phase_nxt  = phase_r;
    drive_nxt  = drive_r;
    pause_nxt  = pause_r;
    frozen_nxt = frozen_r;
    rej        = 1'b0;
    unique case (item.command) inside
      CMD_TICK: begin
        if (!frozen_r) begin
          phase_nxt = phase_inc;
          if (phase_inc == '0) begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (duty_r[i] != '0) drive_nxt[i] = 1'b1;
            end
          end else if (pause_r) begin
            drive_nxt  = '0;
            frozen_nxt = 1'b1;
          end else begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (phase_inc >= duty_r[i]) drive_nxt[i] = 1'b0;
            end
          end
        end
      end
      CMD_SET, CMD_TOGGLE: begin
        if (!arg_ok) begin
          rej = 1'b1;
        end else if (item.command == CMD_TOGGLE && duty_r[ch_idx] != '0) begin
          duty_nxt[ch_idx] = '0;
        end else begin
          duty_nxt[ch_idx] = item.duty;
        end
      end
      CMD_PAUSE: pause_nxt = 1'b1;
      CMD_RESUME: begin
        pause_nxt  = 1'b0;
        frozen_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        duty_r[i] <= '0;
      end
      phase_r  <= '0;
      drive_r  <= '0;
      pause_r  <= 1'b0;
      frozen_r <= 1'b0;
    end else if (upd) begin
      for (int i = 0; i < CHANNELS; i++) begin
        duty_r[i] <= duty_nxt[i];
      end
      phase_r  <= phase_nxt;
      drive_r  <= drive_nxt;
      pause_r  <= pause_nxt;
      frozen_r <= frozen_nxt;
    end
  end

  assign res.lit_mask = drive_nxt;
  assign res.rejected = rej;
  assign res.halted   = frozen_nxt;
  assign res.phase    = phase_nxt;

endmodule

### rtl/multi_channel_led_pwm.sv
// ----------------------------------------------------------------------------
// multi_channel_led_pwm
// Nine-channel PWM for three RGB LEDs with set, toggle, pause and resume.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/stall    command, rgb_index, colour_index, duty
//   out_     output     out_valid/stall   lit_mask, rejected, halted, phase
//
// Each command goes through an input register and then one pass of update
// logic into the output register, one transfer per cycle while the output
// is not stalled. A stalled output holds the input register, and the input
// stalls only then. Synchronous reset clears all duties, the phase, the drive
// and the pause state.
`include "multi_channel_led_pwm_assert.svh"

module multi_channel_led_pwm (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [1:0] in_rgb_index,
  input  logic [1:0] in_colour_index,
  input  logic [3:0] in_duty,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_lit_mask,
  output logic       out_rejected,
  output logic       out_halted,
  output logic [3:0] out_phase
);
  import mclp_pkg::*;

  item_t   item_r;
  logic    item_valid_r;
  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic    advance;

  // The held item moves on when the output register is empty or being drained.
  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.command      <= in_command;
      item_r.rgb_index    <= in_rgb_index;
      item_r.colour_index <= in_colour_index;
      item_r.duty         <= in_duty;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  mclp_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (advance),
    .item  (item_r),
    .res   (res_nxt)
  );

  assign out_valid    = out_valid_r;
  assign out_lit_mask = res_r.lit_mask;
  assign out_rejected = res_r.rejected;
  assign out_halted   = res_r.halted;
  assign out_phase    = res_r.phase;

  // A frozen PWM drives every channel dark.
  `MCLP_ASSERT_IMP(a_halt_dark, out_valid && out_halted, out_lit_mask == '0)
  // The phase counter stays below the level count.
  `MCLP_ASSERT_IMP(a_phase_range, out_valid, 32'(out_phase) < LEVELS)
  // A full input register with a free output never holds the input side.
  `MCLP_ASSERT_IMP(a_no_false_stall, item_valid_r && !out_valid_r, !in_stall)

endmodule

### tb/sv/mclp_pwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_pwm_checker
// Watches both channels of the LED PWM block and tracks its duty table, phase,
// drive and pause state. For every command transfer it computes the status
// word the block must return. Each returned status is compared field by
// field with the oldest computed one.
// ----------------------------------------------------------------------------
module mclp_pwm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mclp_pkg::CMD_W-1:0]    in_command,
  input  logic [mclp_pkg::RGB_W-1:0]    in_rgb_index,
  input  logic [mclp_pkg::COLOUR_W-1:0] in_colour_index,
  input  logic [mclp_pkg::DUTY_W-1:0]   in_duty,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [mclp_pkg::CHANNELS-1:0] out_lit_mask,
  input  logic                          out_rejected,
  input  logic                          out_halted,
  input  logic [mclp_pkg::PHASE_W-1:0]  out_phase,
  output int unsigned                   mismatch_count,
  output int unsigned                   status_backlog
);
  import mclp_pkg::*;

  logic [DUTY_W-1:0]   duty_level [CHANNELS];
  logic [PHASE_W-1:0]  phase_cnt;
  logic [CHANNELS-1:0] lit_bits;
  logic                pause_pending;
  logic                freeze;
  result_t             status_q [$];

  task automatic apply_command(input item_t cmd_item, output result_t status);
    int unsigned ch;
    logic        bad_arg;
    bad_arg = 1'b0;
    case (cmd_item.command) inside
      CMD_TICK: begin
        if (!freeze) begin
          phase_cnt = PHASE_W'((int'(phase_cnt) + 1) % LEVELS);
          for (ch = 0; ch < NUM_CH; ch++) begin
            if (phase_cnt == '0) begin
              if (duty_level[ch] != '0) lit_bits[ch] = 1'b1;
            end else if (phase_cnt >= duty_level[ch]) begin
              lit_bits[ch] = 1'b0;
            end
          end
          // A pending pause only bites on a tick that lands on a nonzero phase.
          if (phase_cnt != '0 && pause_pending) begin
            lit_bits = '0;
            freeze   = 1'b1;
          end
        end
      end
      CMD_SET, CMD_TOGGLE: begin
        if (cmd_item.rgb_index >= RGB_COUNT || cmd_item.colour_index >= COLOURS ||
            cmd_item.duty > LEVELS) begin
          bad_arg = 1'b1;
        end else begin
          ch = cmd_item.rgb_index * COLOURS + cmd_item.colour_index;
          if (cmd_item.command == CMD_TOGGLE && duty_level[ch] != '0) begin
            duty_level[ch] = '0;
          end else begin
            duty_level[ch] = cmd_item.duty;
          end
        end
      end
      CMD_PAUSE: begin
        pause_pending = 1'b1;
      end
      CMD_RESUME: begin
        pause_pending = 1'b0;
        freeze        = 1'b0;
      end
      default: begin
      end
    endcase
    status.lit_mask = lit_bits;
    status.rejected = bad_arg;
    status.halted   = freeze;
    status.phase    = phase_cnt;
  endtask

  always @(posedge clk) begin
    item_t   cmd_item;
    result_t status;
    result_t want;
    int unsigned errs;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) duty_level[i] = '0;
      phase_cnt      = '0;
      lit_bits       = '0;
      pause_pending  = 1'b0;
      freeze         = 1'b0;
      status_q.delete();
      mismatch_count <= 0;
      status_backlog <= 0;
    end else begin
      errs = mismatch_count;
      if (in_valid && !in_stall) begin
        cmd_item.command      = in_command;
        cmd_item.rgb_index    = in_rgb_index;
        cmd_item.colour_index = in_colour_index;
        cmd_item.duty         = in_duty;
        apply_command(cmd_item, status);
        status_q.push_back(status);
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $error("status transfer with no command outstanding");
          errs++;
        end else begin
          want = status_q.pop_front();
          if (out_lit_mask !== want.lit_mask) begin
            $error("lit_mask: expected %h, got %h", want.lit_mask, out_lit_mask);
            errs++;
          end
          if (out_rejected !== want.rejected) begin
            $error("rejected: expected %b, got %b", want.rejected, out_rejected);
            errs++;
          end
          if (out_halted !== want.halted) begin
            $error("halted: expected %b, got %b", want.halted, out_halted);
            errs++;
          end
          if (out_phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_phase);
            errs++;
          end
        end
      end
      mismatch_count <= errs;
      status_backlog <= status_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command transfers into the LED PWM block with random gaps and
// random output stalls. A directed opening covers the argument extremes,
// rejections, toggles and the pause and resume corners; random commands
// follow. The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import mclp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_TOP = '1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  logic [RGB_W-1:0]    in_rgb_index;
  logic [COLOUR_W-1:0] in_colour_index;
  logic [DUTY_W-1:0]   in_duty;
  logic                out_valid;
  logic                out_stall;
  logic [CHANNELS-1:0] out_lit_mask;
  logic                out_rejected;
  logic                out_halted;
  logic [PHASE_W-1:0]  out_phase;
  int unsigned         mismatch_count;
  int unsigned         status_backlog;
  logic                quiet;

  multi_channel_led_pwm i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_rgb_index    (in_rgb_index),
    .in_colour_index (in_colour_index),
    .in_duty         (in_duty),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lit_mask    (out_lit_mask),
    .out_rejected    (out_rejected),
    .out_halted      (out_halted),
    .out_phase       (out_phase)
  );

  mclp_pwm_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned idle_cycles();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [RGB_W-1:0] rgb,
                              input logic [COLOUR_W-1:0] colour,
                              input logic [DUTY_W-1:0] duty);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_rgb_index    <= rgb;
    in_colour_index <= colour;
    in_duty         <= duty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_status();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_backlog != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly ticks and well-formed writes, with occasional bad arguments,
  // short pauses and spare command codes.
  task automatic random_command();
    int unsigned         sel;
    logic [CMD_W-1:0]    cmd;
    logic [RGB_W-1:0]    rgb;
    logic [COLOUR_W-1:0] colour;
    logic [DUTY_W-1:0]   duty;
    sel = $urandom_range(0, 99);
    if (sel < 50)      cmd = CMD_TICK;
    else if (sel < 68) cmd = CMD_SET;
    else if (sel < 84) cmd = CMD_TOGGLE;
    else if (sel < 89) cmd = CMD_PAUSE;
    else if (sel < 95) cmd = CMD_RESUME;
    else               cmd = CMD_W'($urandom_range(int'(CMD_SPARE_TOP), int'(CMD_RESUME) + 1));
    rgb    = ($urandom_range(0, 9) == 0) ? RGB_W'($urandom)
                                         : RGB_W'($urandom_range(0, RGB_COUNT - 1));
    colour = ($urandom_range(0, 9) == 0) ? COLOUR_W'($urandom)
                                         : COLOUR_W'($urandom_range(0, COLOURS - 1));
    duty   = ($urandom_range(0, 7) == 0) ? DUTY_W'($urandom)
                                         : DUTY_W'($urandom_range(0, LEVELS));
    send_command(cmd, rgb, colour, duty);
  endtask

  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int unsigned hold;
      hold = idle_cycles();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_valid        = 1'b0;
    in_command      = CMD_TICK;
    in_rgb_index    = '0;
    in_colour_index = '0;
    in_duty         = '0;
    quiet           = 1'b0;
    rst_n           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A resume while running must leave no credit for a later pause.
    send_command(CMD_RESUME, 2'd0, 2'd0, 4'd0);
    send_command(CMD_SET, 2'd0, 2'd0, DUTY_W'(LEVELS));
    send_command(CMD_SET, RGB_W'(RGB_COUNT - 1), COLOUR_W'(COLOURS - 1), 4'd1);
    send_command(CMD_SET, 2'd1, 2'd1, '1);
    send_command(CMD_SET, '1, 2'd0, 4'd5);
    send_command(CMD_SET, 2'd0, '1, 4'd5);
    send_command(CMD_TOGGLE, 2'd1, 2'd0, 4'd7);
    send_command(CMD_TOGGLE, 2'd1, 2'd0, 4'd3);
    send_command(CMD_TOGGLE, 2'd2, 2'd1, 4'd11);
    send_command(CMD_SPARE_TOP, '1, '1, '1);
    repeat (LEVELS - 1) send_command(CMD_TICK, 2'd0, 2'd0, 4'd0);
    // The pause is requested at the last phase, so the wrap lights without
    // freezing and the following tick freezes.
    send_command(CMD_PAUSE, 2'd0, 2'd0, 4'd0);
    send_command(CMD_TICK, 2'd0, 2'd0, 4'd0);
    send_command(CMD_TICK, 2'd0, 2'd0, 4'd0);
    send_command(CMD_TICK, 2'd0, 2'd0, 4'd0);
    send_command(CMD_PAUSE, 2'd0, 2'd0, 4'd0);
    send_command(CMD_RESUME, 2'd0, 2'd0, 4'd0);
    drain_status();

    for (int n = 0; n < 600; n++) begin
      if (n % 75 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == 300) drain_status();
      random_command();
    end
    drain_status();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
